// ===== design/lbt_pkg.sv =====
// Shared types and constants for the labeled transition table.
package lbt_pkg;

   localparam int NUM_STATES_DEF     = 16;
   localparam int ARCS_PER_STATE_DEF = 8;
   localparam int LABEL_BITS_DEF     = 8;

   // fixed widths of the request and response fields
   localparam int SRC_W      = 4;
   localparam int DST_W      = 4;
   localparam int LABEL_IN_W = 8;
   localparam int NEXT_W     = 4;

   typedef enum logic [1:0] {
      REQ_ADD     = 2'd0,
      REQ_EXISTS  = 2'd1,
      REQ_REMOVE  = 2'd2,
      REQ_TRANSIT = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } rsp_status_type;

   typedef enum logic [2:0] {
      RES_ADDED  = 3'd0,
      RES_FULL   = 3'd1,
      RES_ABSENT = 3'd2,
      RES_FOUND  = 3'd3,
      RES_NEXT   = 3'd4
   } res_kind_type;

   typedef struct packed {
      logic         accept;
      logic         add_wr;
      logic         rd_first;
      logic         rd_next;
      logic         rd_after;
      logic         shift_wr;
      logic         cnt_dec;
      logic         res_set;
      res_kind_type res_kind;
      logic         rsp_load;
   } lbt_cmd_type;

   typedef struct packed {
      req_kind_type req_kind;
      logic         valid_src;
      logic         cnt_zero;
      logic         full;
      logic         match;
      logic         has_next;
      logic         has_next2;
   } lbt_stat_type;

endpackage

// ===== design/lbt_ctrl.sv =====
// Sequencer for the labeled transition table: request intake, list walk, result hand-off.
module lbt_ctrl
   import lbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  lbt_stat_type stat,
   output lbt_cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_COUNT = 5'b00010,
      S_SCAN  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_DONE  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.res_set = 1'b1;
            state_in    = S_DONE;
            if (stat.req_kind == REQ_ADD) begin
               if (!stat.valid_src || stat.full) begin
                  cmd.res_kind = RES_FULL;
               end else begin
                  cmd.add_wr   = 1'b1;
                  cmd.res_kind = RES_ADDED;
               end
            end else if (!stat.valid_src || stat.cnt_zero) begin
               cmd.res_kind = RES_ABSENT;
            end else begin
               cmd.res_set  = 1'b0;
               cmd.rd_first = 1'b1;
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.match) begin
               cmd.res_set = 1'b1;
               state_in    = S_DONE;
               if (stat.req_kind == REQ_TRANSIT) begin
                  cmd.res_kind = RES_NEXT;
               end else begin
                  cmd.res_kind = RES_FOUND;
                  if (stat.req_kind == REQ_REMOVE) begin
                     // close the gap, or just drop the last arc
                     if (stat.has_next) begin
                        cmd.rd_after = 1'b1;
                        state_in     = S_SHIFT;
                     end else begin
                        cmd.cnt_dec = 1'b1;
                     end
                  end
               end
            end else if (stat.has_next) begin
               cmd.rd_next = 1'b1;
            end else begin
               cmd.res_set  = 1'b1;
               cmd.res_kind = RES_ABSENT;
               state_in     = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (!stat.has_next2) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lbt_datapath.sv =====
// Arc memory, per-state count memory, request and result registers of the transition table.
module lbt_datapath
   import lbt_pkg::*;
#(
   parameter int NUM_STATES     = NUM_STATES_DEF,
   parameter int ARCS_PER_STATE = ARCS_PER_STATE_DEF,
   parameter int LABEL_BITS     = LABEL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lbt_cmd_type           cmd,
   output lbt_stat_type          stat,
   input  logic [1:0]            in_kind,
   input  logic [SRC_W-1:0]      in_src,
   input  logic [DST_W-1:0]      in_dst,
   input  logic [LABEL_IN_W-1:0] in_label,
   output logic                  out_found,
   output logic [NEXT_W-1:0]     out_next,
   output logic [1:0]            out_status
);

   localparam int SW    = $clog2(NUM_STATES);
   localparam int CW    = $clog2(ARCS_PER_STATE + 1);
   localparam int IW    = (ARCS_PER_STATE > 1) ? $clog2(ARCS_PER_STATE) : 1;
   localparam int DEPTH = NUM_STATES * ARCS_PER_STATE;
   localparam int AW    = $clog2(DEPTH);
   localparam int XW    = ((SW > SRC_W) ? SW : SRC_W) + 1;
   localparam int LXW   = (LABEL_BITS > LABEL_IN_W) ? LABEL_BITS : LABEL_IN_W;
   localparam int EW    = DST_W + LABEL_BITS;

   // request registers
   req_kind_type          kind_ff;
   logic [SW-1:0]         st_ff;
   logic                  vsrc_ff;
   logic [DST_W-1:0]      dst_ff;
   logic [LABEL_BITS-1:0] lab_ff;

   // walk registers
   logic [CW-1:0]         cnt_ff;
   logic [IW-1:0]         idx_ff;
   logic [EW-1:0]         rd_ff;

   // result and output registers
   logic                  res_found_ff;
   logic [NEXT_W-1:0]     res_next_ff;
   rsp_status_type        res_status_ff;
   logic                  rsp_found_ff;
   logic [NEXT_W-1:0]     rsp_next_ff;
   rsp_status_type        rsp_status_ff;

   // memories
   logic [EW-1:0]         arc_mem [DEPTH];
   logic [CW-1:0]         cnt_mem [NUM_STATES];
   logic [NUM_STATES-1:0] cvld_ff;

   logic [XW-1:0]         src_x;
   logic                  in_valid;
   logic [SW-1:0]         in_st;
   logic [LXW-1:0]        lab_x;

   logic [CW-1:0]         idx_c;
   logic [CW-1:0]         idx1;
   logic [CW:0]           idx2;
   logic [AW-1:0]         base;
   logic [CW:0]           rd_off;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;
   logic                  cnt_we;
   logic [CW-1:0]         cnt_wdata;
   logic [DST_W-1:0]      rd_dst;
   logic [LABEL_BITS-1:0] rd_lab;

   logic                  res_found_in;
   logic [NEXT_W-1:0]     res_next_in;
   rsp_status_type        res_status_in;

   assign src_x    = XW'(in_src);
   assign in_valid = src_x < XW'(NUM_STATES);
   assign in_st    = src_x[SW-1:0];
   assign lab_x    = LXW'(in_label);

   assign idx_c = CW'(idx_ff);
   assign idx1  = idx_c + CW'(1);
   assign idx2  = {1'b0, idx1} + (CW + 1)'(1);
   assign base  = AW'(st_ff) * AW'(ARCS_PER_STATE);

   assign rd_dst = rd_ff[DST_W-1:0];
   assign rd_lab = rd_ff[EW-1:DST_W];

   assign stat.req_kind  = kind_ff;
   assign stat.valid_src = vsrc_ff;
   assign stat.cnt_zero  = (cnt_ff == '0);
   assign stat.full      = (cnt_ff >= CW'(ARCS_PER_STATE));
   assign stat.match     = (rd_lab == lab_ff) && ((kind_ff == REQ_TRANSIT) || (rd_dst == dst_ff));
   assign stat.has_next  = (idx1 < cnt_ff);
   assign stat.has_next2 = (idx2 < {1'b0, cnt_ff});

   // read offset within the list: first, following, or two ahead while shifting
   always_comb begin
      rd_off = '0;
      if (cmd.rd_next || cmd.rd_after) begin
         rd_off = {1'b0, idx1};
      end else if (cmd.shift_wr) begin
         rd_off = idx2;
      end
   end

   assign rd_en   = cmd.rd_first || cmd.rd_next || cmd.rd_after ||
                    (cmd.shift_wr && stat.has_next2);
   assign rd_addr = base + AW'(rd_off);

   assign wr_en   = cmd.add_wr || cmd.shift_wr;
   assign wr_addr = base + (cmd.add_wr ? AW'(cnt_ff) : AW'(idx_c));
   assign wr_data = cmd.add_wr ? {lab_ff, dst_ff} : rd_ff;

   assign cnt_we    = cmd.add_wr || cmd.cnt_dec;
   assign cnt_wdata = cmd.add_wr ? (cnt_ff + CW'(1)) : (cnt_ff - CW'(1));

   always_comb begin
      res_found_in  = 1'b0;
      res_next_in   = '0;
      res_status_in = ST_ABSENT;
      unique case (cmd.res_kind)
         RES_ADDED: begin
            res_status_in = ST_OK;
         end
         RES_FULL: begin
            res_status_in = ST_FULL;
         end
         RES_ABSENT: begin
            res_status_in = ST_ABSENT;
         end
         RES_FOUND: begin
            res_found_in  = 1'b1;
            res_status_in = ST_OK;
         end
         RES_NEXT: begin
            res_found_in  = 1'b1;
            res_next_in   = NEXT_W'(rd_dst);
            res_status_in = ST_OK;
         end
         default: begin
            res_status_in = ST_ABSENT;
         end
      endcase
   end

   // arc memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         arc_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= arc_mem[rd_addr];
      end
   end

   // count memory; an entry without its valid bit reads as zero
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[st_ff] <= cnt_wdata;
      end
      if (cmd.accept) begin
         cnt_ff <= (in_valid && cvld_ff[in_st]) ? cnt_mem[in_st] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvld_ff <= '0;
      end else if (cnt_we) begin
         cvld_ff[st_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind_type'(in_kind);
         st_ff   <= in_st;
         vsrc_ff <= in_valid;
         dst_ff  <= in_dst;
         lab_ff  <= lab_x[LABEL_BITS-1:0];
      end
      if (cmd.rd_first) begin
         idx_ff <= '0;
      end else if (cmd.rd_next || cmd.shift_wr) begin
         idx_ff <= idx1[IW-1:0];
      end
      if (cmd.res_set) begin
         res_found_ff  <= res_found_in;
         res_next_ff   <= res_next_in;
         res_status_ff <= res_status_in;
      end
      if (cmd.rsp_load) begin
         rsp_found_ff  <= res_found_ff;
         rsp_next_ff   <= res_next_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign out_found  = rsp_found_ff;
   assign out_next   = rsp_next_ff;
   assign out_status = rsp_status_ff;

endmodule

// ===== design/labeled_transition_table.sv =====
// Top level of the labeled transition table: stream ports, sequencer and datapath.
//
// Stores up to ARCS_PER_STATE labeled arcs per source state, in insertion order, and serves
// one request at a time: add, exists, remove and transit. Every request gives one response.
// An add, or any lookup on an empty list or an out-of-range state, is answered without a
// walk. Exists and transit walk the source state's list one arc per cycle until the first
// match or the end of the list. A remove that hits position k in a list of n arcs also
// moves the n-k-1 later arcs up one place, one per cycle. The one read port of the arc
// memory sets this pace. The response register lets the next request be accepted while
// a response waits. Arc counts are cleared at reset through per-state valid bits, so there
// is no clearing pass.
module labeled_transition_table
   import lbt_pkg::*;
#(
   parameter int NUM_STATES     = NUM_STATES_DEF,
   parameter int ARCS_PER_STATE = ARCS_PER_STATE_DEF,
   parameter int LABEL_BITS     = LABEL_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // src_state[3:0], dst_state[7:4], label[15:8]
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // found[0], next_state[4:1], zero[7:5]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   lbt_cmd_type       cmd;
   lbt_stat_type      stat;
   logic              found;
   logic [NEXT_W-1:0] next_state;
   logic [1:0]        status;

   lbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lbt_datapath #(
      .NUM_STATES     (NUM_STATES),
      .ARCS_PER_STATE (ARCS_PER_STATE),
      .LABEL_BITS     (LABEL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_kind    (req_tuser),
      .in_src     (req_tdata[3:0]),
      .in_dst     (req_tdata[7:4]),
      .in_label   (req_tdata[15:8]),
      .out_found  (found),
      .out_next   (next_state),
      .out_status (status)
   );

   assign rsp_tdata = {3'b000, next_state, found};
   assign rsp_tuser = status;

endmodule

// ===== verif/tb.sv =====
// Testbench for labeled_transition_table: stream driver, response monitor and arc list predictor.
`timescale 1ns / 100ps

module tb;
   import lbt_pkg::*;

   localparam int NSTATES     = NUM_STATES_DEF;
   localparam int ARCS        = ARCS_PER_STATE_DEF;
   localparam int RANDOM_REQS = 750;
   localparam int DRAIN_CYCLES = 2 * ARCS + 24;

   typedef struct packed {
      req_kind_type kind;
      logic [3:0]   src;
      logic [3:0]   dst;
      logic [7:0]   label;
   } arc_req_type;

   typedef struct packed {
      logic           found;
      logic [3:0]     next_st;
      rsp_status_type status;
   } arc_rsp_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0] req_tuser  = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   arc_req_type req_backlog[$];
   arc_rsp_type expected_rsp[$];
   int       req_accepted = 0;
   int       total_reqs   = 1;
   int       errors       = 0;
   bit       req_fired    = 1'b0;

   // shadow copy of the arc lists
   logic [3:0] arc_dst [NSTATES][ARCS];
   logic [7:0] arc_lab [NSTATES][ARCS];
   int         arc_cnt [NSTATES];

   labeled_transition_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic arc_rsp_type lookup_arc(arc_req_type r);
      arc_rsp_type res;
      int       n;
      int       pos;
      res = '{found: 1'b0, next_st: 4'd0, status: ST_ABSENT};
      n   = arc_cnt[r.src];
      pos = -1;
      if (r.kind == REQ_ADD) begin
         if (n < ARCS) begin
            arc_dst[r.src][n] = r.dst;
            arc_lab[r.src][n] = r.label;
            arc_cnt[r.src]    = n + 1;
            res.status        = ST_OK;
         end else begin
            res.status = ST_FULL;
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            if (pos < 0 && arc_lab[r.src][i] == r.label &&
                (r.kind == REQ_TRANSIT || arc_dst[r.src][i] == r.dst))
               pos = i;
         end
         if (pos >= 0) begin
            res.found  = 1'b1;
            res.status = ST_OK;
            if (r.kind == REQ_TRANSIT)
               res.next_st = arc_dst[r.src][pos];
            if (r.kind == REQ_REMOVE) begin
               // close the gap: later arcs move up one place
               for (int i = pos; i + 1 < n; i++) begin
                  arc_dst[r.src][i] = arc_dst[r.src][i + 1];
                  arc_lab[r.src][i] = arc_lab[r.src][i + 1];
               end
               arc_cnt[r.src] = n - 1;
            end
         end
      end
      return res;
   endfunction

   // idle percentage for the current phase; sender and receiver swap in phase 1
   function automatic int idle_pct(bit sender);
      int phase;
      phase = (req_accepted * 3) / total_reqs;
      if (phase == 0)
         return sender ? 24 : 76;
      else if (phase == 1)
         return sender ? 76 : 24;
      return 0;
   endfunction

   function automatic arc_req_type random_request();
      arc_req_type r;
      int       sel;
      sel = $urandom_range(0, 99);
      if (sel < 38)
         r.kind = REQ_ADD;
      else if (sel < 58)
         r.kind = REQ_EXISTS;
      else if (sel < 78)
         r.kind = REQ_REMOVE;
      else
         r.kind = REQ_TRANSIT;
      // favor a few states and labels so lists fill up and lookups hit
      r.src   = 4'(($urandom_range(0, 99) < 50) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15));
      r.dst   = 4'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 15));
      r.label = 8'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 255));
      return r;
   endfunction

   task automatic queue_req(req_kind_type kind, int src, int dst, int label);
      arc_req_type r;
      r.kind  = kind;
      r.src   = 4'(src);
      r.dst   = 4'(dst);
      r.label = 8'(label);
      req_backlog.push_back(r);
   endtask

   // driver: present requests and set rsp_tready at the falling edge
   always @(negedge clock) begin
      arc_req_type r;
      if (!reset && (!req_tvalid || req_fired)) begin
         if (req_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
            r = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {r.label, r.dst, r.src};
            req_tuser  <= r.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !reset && ($urandom_range(0, 99) >= idle_pct(1'b0));
   end

   // monitor: take requests and responses at the rising edge
   always @(posedge clock) begin
      arc_req_type r;
      arc_rsp_type got;
      arc_rsp_type want;
      req_fired = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r.kind  = req_kind_type'(req_tuser);
            r.src   = req_tdata[3:0];
            r.dst   = req_tdata[7:4];
            r.label = req_tdata[15:8];
            expected_rsp.push_back(lookup_arc(r));
            req_accepted++;
            req_fired = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found   = rsp_tdata[0];
            got.next_st = rsp_tdata[4:1];
            got.status  = rsp_status_type'(rsp_tuser);
            if (expected_rsp.size() == 0) begin
               $error("response with none pending: found=%0d next_state=%0d status=%0d",
                      got.found, got.next_st, got.status);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (got.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, got.found);
                  errors++;
               end
               if (got.next_st !== want.next_st) begin
                  $error("next_state: expected %0d, actual %0d", want.next_st, got.next_st);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors++;
               end
               if (rsp_tdata[7:5] !== 3'b000) begin
                  $error("rsp_tdata pad: expected 0, actual %0d", rsp_tdata[7:5]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      for (int s = 0; s < NSTATES; s++)
         arc_cnt[s] = 0;

      // extremes of the fields
      queue_req(REQ_ADD, 0, 0, 0);
      queue_req(REQ_ADD, 15, 15, 255);
      queue_req(REQ_EXISTS, 15, 15, 255);
      queue_req(REQ_EXISTS, 0, 1, 0);
      queue_req(REQ_TRANSIT, 15, 0, 255);
      queue_req(REQ_TRANSIT, 0, 0, 1);
      queue_req(REQ_TRANSIT, 5, 0, 0);
      // fill one list, then overflow it
      for (int i = 0; i < ARCS; i++)
         queue_req(REQ_ADD, 3, i, i);
      queue_req(REQ_ADD, 3, 9, 9);
      // remove from the middle, then look again
      queue_req(REQ_REMOVE, 3, 2, 2);
      queue_req(REQ_EXISTS, 3, 2, 2);
      queue_req(REQ_REMOVE, 3, 2, 2);
      // empty a list down to zero
      queue_req(REQ_REMOVE, 0, 0, 0);
      queue_req(REQ_REMOVE, 0, 0, 0);
      // duplicate arc: remove drops only the first copy
      queue_req(REQ_ADD, 15, 15, 255);
      queue_req(REQ_REMOVE, 15, 15, 255);
      queue_req(REQ_EXISTS, 15, 15, 255);

      for (int i = 0; i < RANDOM_REQS; i++)
         req_backlog.push_back(random_request());
      total_reqs = req_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (req_accepted < total_reqs || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lbt_pkg.sv
design/lbt_ctrl.sv
design/lbt_datapath.sv
design/labeled_transition_table.sv
verif/tb.sv
